/* rtl/core/eop_pkg.sv */
// ----------------------------------------------------------------------------
// eop_pkg - EXIF orientation parser package
// Parse phases and format constants shared by the orientation parser.
// ----------------------------------------------------------------------------
package eop_pkg;

    localparam int unsigned MAX_SEGMENT_BYTES = 65536;

    localparam logic [15:0] ORIENT_TAG        = 16'h0112;
    localparam logic [16:0] ENTRY_BYTES       = 17'd12;
    localparam logic [15:0] TIFF_HEADER_BYTES = 16'd8;
    localparam logic [7:0]  MAX_ORIENT        = 8'd8;
    localparam logic [7:0]  TIFF_MARK         = 8'h2A;
    localparam logic [7:0]  ORDER_INTEL       = 8'h49;  // "II"
    localparam logic [7:0]  ORDER_MOTOROLA    = 8'h4D;  // "MM"
    localparam logic [15:0] EXIF_HDR_BYTES    = 16'd6;

    localparam logic [7:0] EXIF_MAGIC [6] = '{8'h45, 8'h78, 8'h69, 8'h66, 8'h00, 8'h00};

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_TIFF,
        PH_COUNT,
        PH_ENTRY,
        PH_TAGGED,
        PH_FOUND,
        PH_FAIL
    } phase_t;

endpackage

/* rtl/core/exif_orientation_parser.sv */
// ----------------------------------------------------------------------------
// exif_orientation_parser - EXIF orientation tag scanner
// Walks one APP1 payload a byte per beat and reports the orientation tag.
// ----------------------------------------------------------------------------
// Accepts one payload byte per clock, back to back, and returns one result
// beat for the beat flagged last_byte: orientation 1..8, or 0 when the Exif or
// TIFF header is bad, the first IFD sits below offset 8 or above 64K, the tag
// is missing, the value is out of range, or the payload ends early. Bytes go
// through an input register and then compare/counter logic, and the result
// for a last byte is registered in the output stage; the input side only
// stalls while a finished result is still held and the next last byte waits.
// After each result the scanner is back in its reset state for the next
// payload.
module exif_orientation_parser (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_last_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [3:0] m_orient
);
    import eop_pkg::*;

    // input stage
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // scanner state
    phase_t      phase_reg,      phase_next;
    logic [15:0] byte_pos_reg,   byte_pos_next;
    logic        big_endian_reg, big_endian_next;
    logic [15:0] dir_off_reg,    dir_off_next;
    logic [15:0] entries_reg,    entries_next;
    logic [16:0] entry_start_reg, entry_start_next;
    logic [7:0]  held_reg,       held_next;
    logic [3:0]  found_reg,      found_next;

    // result stage
    logic       m_valid_reg;
    logic [3:0] m_orient_reg;
    logic [3:0] result_orient;

    logic advance;

    function automatic logic [15:0] join16(input logic be, input logic [7:0] first,
                                           input logic [7:0] second);
        return be ? {first, second} : {second, first};
    endfunction

    assign advance = in_valid_reg && (!in_last_reg || !m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign m_valid  = m_valid_reg;
    assign m_orient = m_orient_reg;

    // ------------------------------------------------------------------------
    // next-state logic
    // ------------------------------------------------------------------------
    always_comb begin
        logic [7:0]  b;
        logic [15:0] idx;
        logic [15:0] bp;
        logic [16:0] bp17;
        logic [16:0] k;
        logic [15:0] ofs;
        logic [15:0] cnt;
        logic [7:0]  value;
        logic [7:0]  other;

        b    = in_byte_reg;
        idx  = byte_pos_reg;
        bp   = idx - EXIF_HDR_BYTES;
        bp17 = {1'b0, bp};
        k    = bp17 - entry_start_reg;
        ofs  = '0;
        cnt  = '0;
        value = big_endian_reg ? b : held_reg;
        other = big_endian_reg ? held_reg : b;

        phase_next       = phase_reg;
        byte_pos_next    = byte_pos_reg;
        big_endian_next  = big_endian_reg;
        dir_off_next     = dir_off_reg;
        entries_next     = entries_reg;
        entry_start_next = entry_start_reg;
        held_next        = held_reg;
        found_next       = found_reg;

        if (phase_reg == PH_HEADER) begin
            if (idx < EXIF_HDR_BYTES) begin
                if (b != EXIF_MAGIC[idx[2:0]]) begin
                    phase_next = PH_FAIL;
                end else if (idx == EXIF_HDR_BYTES - 16'd1) begin
                    phase_next = PH_TIFF;
                end
            end else begin
                phase_next = PH_FAIL;
            end
        end else if (idx >= EXIF_HDR_BYTES) begin
            unique case (phase_reg)
                PH_TIFF: begin
                    case (bp)
                        16'd0: begin
                            if (b == ORDER_INTEL) begin
                                big_endian_next = 1'b0;
                                held_next       = b;
                            end else if (b == ORDER_MOTOROLA) begin
                                big_endian_next = 1'b1;
                                held_next       = b;
                            end else begin
                                phase_next = PH_FAIL;
                            end
                        end
                        16'd1: if (b != held_reg) phase_next = PH_FAIL;
                        16'd2: if (b != (big_endian_reg ? 8'h00 : TIFF_MARK)) phase_next = PH_FAIL;
                        16'd3: if (b != (big_endian_reg ? TIFF_MARK : 8'h00)) phase_next = PH_FAIL;
                        16'd4: begin
                            if (big_endian_reg) begin
                                if (b != 8'h00) phase_next = PH_FAIL;
                            end else begin
                                held_next = b;
                            end
                        end
                        16'd5: begin
                            if (big_endian_reg) begin
                                if (b != 8'h00) phase_next = PH_FAIL;
                            end else begin
                                dir_off_next = join16(1'b0, held_reg, b);
                            end
                        end
                        16'd6: begin
                            if (big_endian_reg) begin
                                held_next = b;
                            end else if (b != 8'h00) begin
                                phase_next = PH_FAIL;
                            end
                        end
                        default: begin
                            // last offset byte: offset must clear the TIFF header
                            if (big_endian_reg) begin
                                ofs          = join16(1'b1, held_reg, b);
                                dir_off_next = ofs;
                                phase_next   = (ofs < TIFF_HEADER_BYTES) ? PH_FAIL : PH_COUNT;
                            end else if (b != 8'h00) begin
                                phase_next = PH_FAIL;
                            end else begin
                                phase_next = (dir_off_reg < TIFF_HEADER_BYTES) ? PH_FAIL
                                                                                : PH_COUNT;
                            end
                        end
                    endcase
                end
                PH_COUNT: begin
                    if (bp == dir_off_reg) begin
                        held_next = b;
                    end else if (bp17 == {1'b0, dir_off_reg} + 17'd1) begin
                        cnt          = join16(big_endian_reg, held_reg, b);
                        entries_next = cnt;
                        if (cnt == 16'd0) begin
                            phase_next = PH_FAIL;
                        end else begin
                            entry_start_next = {1'b0, dir_off_reg} + 17'd2;
                            phase_next       = PH_ENTRY;
                        end
                    end
                end
                PH_ENTRY, PH_TAGGED: begin
                    if (bp17 >= entry_start_reg) begin
                        if (k == 17'd0) begin
                            held_next = b;
                        end else if (k == 17'd1) begin
                            if (join16(big_endian_reg, held_reg, b) == ORIENT_TAG) begin
                                phase_next = PH_TAGGED;
                            end
                        end else if (k == 17'd8) begin
                            held_next = b;
                        end else if (k == 17'd9 && phase_reg == PH_TAGGED) begin
                            if (other != 8'h00 || value > MAX_ORIENT) begin
                                phase_next = PH_FAIL;
                            end else begin
                                found_next = value[3:0];
                            end
                        end else if (k == ENTRY_BYTES - 17'd1) begin
                            if (phase_reg == PH_TAGGED) begin
                                phase_next = PH_FOUND;
                            end else begin
                                entries_next = entries_reg - 16'd1;
                                if (entries_reg == 16'd1) begin
                                    phase_next = PH_FAIL;
                                end else begin
                                    entry_start_next = entry_start_reg + ENTRY_BYTES;
                                end
                            end
                        end
                    end
                end
                default: begin
                    // found or failed: remaining bytes are ignored
                end
            endcase
        end

        // result value (taken from the updated phase before the end-of-payload reset)
        result_orient = (phase_next == PH_FOUND) ? found_next : 4'd0;

        if (in_last_reg) begin
            phase_next       = PH_HEADER;
            byte_pos_next    = '0;
            big_endian_next  = 1'b0;
            dir_off_next     = '0;
            entries_next     = '0;
            entry_start_next = '0;
            held_next        = '0;
            found_next       = '0;
        end else begin
            if ({1'b0, idx} + 17'd1 >= 17'(MAX_SEGMENT_BYTES)) phase_next = PH_FAIL;
            if (idx != 16'hFFFF) byte_pos_next = idx + 16'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
            in_last_reg <= s_last_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_HEADER;
            byte_pos_reg    <= '0;
            big_endian_reg  <= 1'b0;
            dir_off_reg     <= '0;
            entries_reg     <= '0;
            entry_start_reg <= '0;
            held_reg        <= '0;
            found_reg       <= '0;
        end else if (advance) begin
            phase_reg       <= phase_next;
            byte_pos_reg    <= byte_pos_next;
            big_endian_reg  <= big_endian_next;
            dir_off_reg     <= dir_off_next;
            entries_reg     <= entries_next;
            entry_start_reg <= entry_start_next;
            held_reg        <= held_next;
            found_reg       <= found_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (advance && in_last_reg) begin
            m_orient_reg <= result_orient;
        end
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_result_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(in_valid_reg && in_last_reg))
        else $error("result beat without a last byte");

    a_orient_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_orient_reg <= 4'd8))
        else $error("orientation out of range");

    a_rearm_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_last_reg) |=> (phase_reg == PH_HEADER && byte_pos_reg == 16'd0))
        else $error("scanner not rearmed after payload end");

    a_input_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("stalled input byte lost");

endmodule
